FILE: sv/alnsplit_pkg.sv
// shared types and constants for the alignment line splitter / NH tag extractor
// no dependencies
`default_nettype none

package alnsplit_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned NhW     = 16;
	localparam int unsigned HistLen = 5;
	localparam int unsigned DataW   = 32;
	localparam int unsigned UserW   = 2;

	localparam logic [ByteW-1:0] ChTab   = 8'h09;
	localparam logic [ByteW-1:0] ChColon = 8'h3A;
	localparam logic [ByteW-1:0] ChI     = 8'h69;
	localparam logic [ByteW-1:0] ChH     = 8'h48;
	localparam logic [ByteW-1:0] ChN     = 8'h4E;
	localparam logic [ByteW-1:0] ChZero  = 8'h30;
	localparam logic [ByteW-1:0] ChNine  = 8'h39;

	localparam logic [NhW-1:0] NhSat = {NhW{1'b1}};

	typedef enum logic [1:0] {
		NH_SEARCH = 2'd0,
		NH_DIGITS = 2'd1,
		NH_DONE   = 2'd2
	} nh_phase_t;

	typedef struct packed {
		logic           found;
		logic [NhW-1:0] value;
	} nh_result_t;

	// accum * 10 + digit, saturating
	function automatic logic [NhW-1:0] add_digit(input logic [NhW-1:0] acc,
			input logic [ByteW-1:0] c);
		logic [NhW+4:0] v;
		v = {2'b00, acc, 3'b000} + {4'b0000, acc, 1'b0} + {{(NhW+1){1'b0}}, c[3:0]};
		return (v > {5'b0, NhSat}) ? NhSat : v[NhW-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: sv/alnsplit_nh_parse.sv
// NH:i: tag detector and decimal count gatherer, one byte per transfer
// depends on alnsplit_pkg
`default_nettype none

module alnsplit_nh_parse (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       take,
	input  wire logic [alnsplit_pkg::ByteW-1:0] line_byte,
	input  wire logic                       line_end,
	input  wire logic                       dropped,
	output alnsplit_pkg::nh_result_t        result
);
	import alnsplit_pkg::*;

	logic [ByteW-1:0] hist_q [HistLen];
	nh_phase_t        phase_q, phase_d;
	logic [NhW-1:0]   accum_q, accum_d;
	logic             is_digit, tag_seen;

	assign is_digit = (line_byte >= ChZero) && (line_byte <= ChNine);
	assign tag_seen = (hist_q[0] == ChN) && (hist_q[1] == ChH) && (hist_q[2] == ChColon)
		&& (hist_q[3] == ChI) && (hist_q[4] == ChColon);

	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		unique case (phase_q)
			NH_SEARCH: begin
				if (!dropped && tag_seen) begin
					if (is_digit) begin
						accum_d = add_digit('0, line_byte);
						phase_d = NH_DIGITS;
					end else begin
						phase_d = NH_DONE;
					end
				end
			end
			NH_DIGITS: begin
				if (is_digit) begin
					accum_d = add_digit(accum_q, line_byte);
				end else begin
					phase_d = NH_DONE;
				end
			end
			NH_DONE: begin
			end
			default: begin
				phase_d = NH_DONE;
			end
		endcase
	end

	// reported only on the line's last byte
	always_comb begin
		result.found = line_end && (phase_d != NH_SEARCH);
		result.value = result.found ? accum_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= NH_SEARCH;
			accum_q <= '0;
			for (int i = 0; i < HistLen; i++) hist_q[i] <= '0;
		end else if (take) begin
			if (line_end) begin
				phase_q <= NH_SEARCH;
				accum_q <= '0;
				for (int i = 0; i < HistLen; i++) hist_q[i] <= '0;
			end else begin
				phase_q <= phase_d;
				accum_q <= accum_d;
				for (int i = 0; i < HistLen - 1; i++) hist_q[i] <= hist_q[i+1];
				hist_q[HistLen-1] <= line_byte;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/alignment_line_split_nh_extract_top.sv
// top level: first-tab splitter and NH count extractor for alignment text lines
// depends on alnsplit_pkg, alnsplit_nh_parse
//
// Input stream: one byte of a text line per transfer, tlast on the line's last byte.
// Output stream: exactly one transfer per input byte carrying the byte, whether it
// lies after the first tab (part) and whether it is kept (the first tab is not).
// On the transfer with tlast the NH:i: count (saturating at 65535) and a found
// flag are filled in; elsewhere they read zero.
// Output valid rises in the cycle after the input transfer. Throughput is one byte
// per cycle while m_tready holds: all per-byte work (history compare, times-ten
// add) sits between the line state registers and the single output register.
// A stalled receiver holds the output register; the input side then takes a new
// byte only in the cycle the held result leaves, so no item is lost or repeated.
// Reset clears the line state and the output valid; a new line starts after
// reset and after every tlast.
`default_nettype none

module alignment_line_split_nh_extract_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output wire logic                            s_tready,
	input  wire logic [alnsplit_pkg::ByteW-1:0]  s_tdata,  // [7:0] line_byte
	input  wire logic                            s_tlast,  // line_end
	output wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	// [7:0] byte_out, [23:8] tag_count, [24] nh_found
	output wire logic [alnsplit_pkg::DataW-1:0]  m_tdata,
	output wire logic [alnsplit_pkg::UserW-1:0]  m_tuser,  // [0] part, [1] byte_valid
	output wire logic                            m_tlast   // last
);
	import alnsplit_pkg::*;

	logic             take;
	logic             after_tab_q;
	logic             dropped;
	nh_result_t       nh_res;

	logic             valid_q;
	logic [DataW-1:0] data_q;
	logic [UserW-1:0] user_q;
	logic             last_q;

	assign s_tready = !valid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign dropped  = (s_tdata == ChTab) && !after_tab_q;

	alnsplit_nh_parse u_nh (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.line_byte (s_tdata),
		.line_end  (s_tlast),
		.dropped   (dropped),
		.result    (nh_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_tab_q <= 1'b0;
			valid_q     <= 1'b0;
		end else begin
			if (take) begin
				after_tab_q <= s_tlast ? 1'b0 : (after_tab_q || dropped);
			end
			if (take) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= {{(DataW - ByteW - NhW - 1){1'b0}}, nh_res.found, nh_res.value, s_tdata};
			user_q <= {!dropped, after_tab_q && !dropped};
			last_q <= s_tlast;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// testbench for alignment_line_split_nh_extract_top: first-tab split and NH:i: count per line
// depends on alnsplit_pkg and the block's rtl; self-checking against an in-line line model
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import alnsplit_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int CalmTail    = 150;
	localparam int RandomItems = 1100;

	typedef struct {
		logic [ByteW-1:0] ch;
		logic             eol;
		bit               wait_idle;
	} line_byte_t;

	typedef struct packed {
		logic             part;
		logic [ByteW-1:0] ch;
		logic             kept;
		logic [NhW-1:0]   tag_count;
		logic             found;
		logic             eol;
	} split_result_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [ByteW-1:0]     s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DataW-1:0]     m_tdata;
	logic [UserW-1:0]     m_tuser;
	logic                 m_tlast;

	line_byte_t       pending_bytes[$];
	logic [ByteW-1:0] line_buf[$];
	split_result_t    expected_splits[$];

	// line model state
	logic [5*ByteW-1:0] recent;        // newest byte in the low bits
	logic               past_tab;
	nh_phase_t          nh_phase;
	logic [NhW-1:0]     nh_count;

	int  in_flight = 0;
	int  results_seen = 0;
	int  mismatches = 0;
	int  cycle_count = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  holdoff_left = 0;
	bit  holdoff_done = 0;
	bit  calm = 0;

	alignment_line_split_nh_extract_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic split_result_t split_byte(input logic [ByteW-1:0] c, input logic eol);
		split_result_t r;
		logic          is_digit;
		logic          dropped;
		logic          take;
		int unsigned   sum;
		is_digit = (c >= ChZero) && (c <= ChNine);
		dropped = (c == ChTab) && !past_tab;
		take = 1'b0;
		r.part = past_tab;
		if (dropped)
			past_tab = 1'b1;
		if (nh_phase == NH_DIGITS) begin
			if (is_digit)
				take = 1'b1;
			else
				nh_phase = NH_DONE;
		end else if (nh_phase == NH_SEARCH && !dropped &&
				recent == {ChN, ChH, ChColon, ChI, ChColon}) begin
			if (is_digit) begin
				nh_count = '0;
				nh_phase = NH_DIGITS;
				take = 1'b1;
			end else begin
				nh_phase = NH_DONE;
			end
		end
		if (take) begin
			sum = nh_count * 10 + (c - ChZero);
			nh_count = (sum > NhSat) ? NhSat : sum[NhW-1:0];
		end
		recent = {recent[4*ByteW-1:0], c};
		r.ch = c;
		r.kept = !dropped;
		r.eol = eol;
		r.found = eol && (nh_phase != NH_SEARCH);
		r.tag_count = r.found ? nh_count : '0;
		if (eol) begin
			recent = '0;
			past_tab = 1'b0;
			nh_phase = NH_SEARCH;
			nh_count = '0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [NhW-1:0] want,
			input logic [NhW-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// sender: offers the next byte once the current one has gone
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_gap <= 0;
		end else begin
			calm <= (pending_bytes.size() < CalmTail);
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					s_tvalid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (pending_bytes.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (pending_bytes[0].wait_idle && (s_tvalid || in_flight != 0)) begin
					// hold back until every result so far has come out
					s_tvalid <= 1'b0;
				end else begin
					s_tdata <= pending_bytes[0].ch;
					s_tlast <= pending_bytes[0].eol;
					s_tvalid <= 1'b1;
					pending_bytes.pop_front();
					if (!calm && holdoff_left == 0 && $urandom_range(0, 9) == 0)
						tx_gap <= $urandom_range(1, 16);
				end
			end
		end
	end

	// receiver ready, with one long hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap <= 0;
			holdoff_left <= 0;
			holdoff_done <= 0;
		end else if (holdoff_left != 0) begin
			m_tready <= 1'b0;
			holdoff_left <= holdoff_left - 1;
		end else if (!holdoff_done && results_seen >= 300) begin
			m_tready <= 1'b0;
			holdoff_left <= 399;
			holdoff_done <= 1;
		end else if (rx_gap != 0) begin
			m_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			rx_gap <= $urandom_range(0, 15);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: checks output transfers, then predicts from the input transfer
	always @(posedge clk) begin
		split_result_t want;
		if (!arst_n) begin
			recent = '0;
			past_tab = 1'b0;
			nh_phase = NH_SEARCH;
			nh_count = '0;
			in_flight <= 0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_splits.size() == 0) begin
					$error("output transfer with nothing expected: tdata 0x%0h", m_tdata);
					mismatches++;
				end else begin
					want = expected_splits.pop_front();
					check_field("part", NhW'(want.part), NhW'(m_tuser[0]));
					check_field("byte_out", NhW'(want.ch), NhW'(m_tdata[7:0]));
					check_field("byte_valid", NhW'(want.kept), NhW'(m_tuser[1]));
					check_field("tag_count", want.tag_count, m_tdata[23:8]);
					check_field("nh_found", NhW'(want.found), NhW'(m_tdata[24]));
					check_field("last", NhW'(want.eol), NhW'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				expected_splits.push_back(split_byte(s_tdata, s_tlast));
			in_flight <= expected_splits.size();
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	function automatic logic [ByteW-1:0] text_byte();
		string alphabet;
		alphabet = "ACGTNHi:0123456789 +-*\t";
		if ($urandom_range(0, 7) == 0)
			return ByteW'($urandom_range(0, 255));
		return alphabet[$urandom_range(0, alphabet.len() - 1)];
	endfunction

	task automatic put_filler(input int n);
		repeat (n) line_buf.push_back(text_byte());
	endtask

	task automatic put_tag();
		int sign_pick;
		put_text("NH:i:");
		sign_pick = $urandom_range(0, 11);
		if (sign_pick == 0)
			put_text("+");
		else if (sign_pick == 1)
			put_text("-");
		else if (sign_pick == 2)
			put_text(" ");
		repeat ($urandom_range(0, 6))
			line_buf.push_back(ByteW'(ChZero + $urandom_range(0, 9)));
	endtask

	task automatic finish_line(input bit hold);
		line_byte_t item;
		if (line_buf.size() == 0)
			line_buf.push_back(text_byte());
		foreach (line_buf[i]) begin
			item.ch = line_buf[i];
			item.eol = (i == line_buf.size() - 1);
			item.wait_idle = hold && (i == 0);
			pending_bytes.push_back(item);
		end
		line_buf.delete();
	endtask

	task automatic random_line();
		int fields;
		int tag_field;
		if ($urandom_range(0, 9) < 7) begin
			// tab-separated fields, usually with a tag in one of them
			fields = $urandom_range(1, 4);
			tag_field = $urandom_range(0, fields);
			for (int f = 0; f < fields; f++) begin
				if (f != 0)
					line_buf.push_back(ChTab);
				put_filler($urandom_range(0, 3));
				if (f == tag_field || $urandom_range(0, 15) == 0)
					put_tag();
				put_filler($urandom_range(0, 5));
			end
		end else begin
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(0, 1) == 0)
					line_buf.push_back(ByteW'($urandom_range(0, 255)));
				else if ($urandom_range(0, 3) == 0)
					put_text("NH:i:");
				else
					line_buf.push_back(text_byte());
			end
		end
	endtask

	initial begin : stimulus
		int line_no;
		int directed_count;
		// tab at line start, tag then a sign
		put_text("\tNH:i:-");
		finish_line(0);
		// dropped tab right after the tag is never taken as the byte after it
		put_text("NH:i:\t");
		finish_line(0);
		// saturation, run closed by the line end
		put_text("NH:i:70000");
		finish_line(0);
		// tag split across two lines must not match
		line_buf.push_back(8'hFF);
		put_text("NH:i");
		finish_line(0);
		put_text(":5");
		finish_line(0);
		line_buf.push_back(8'h00);
		finish_line(0);

		directed_count = pending_bytes.size();
		line_no = 0;
		while (pending_bytes.size() < directed_count + RandomItems) begin
			random_line();
			finish_line(line_no == 0 || line_no == 40);
			line_no++;
		end

		while (pending_bytes.size() != 0 || s_tvalid || in_flight != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (expected_splits.size() != 0) begin
			$error("%0d expected results never arrived", expected_splits.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
